// ----- src/assert_macros.svh -----
// Assertion macros included by the butterfly unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/nlbu_pkg.sv -----
`timescale 1ns / 1ps

package nlbu_pkg;

  // Depth of the datapath, from an accepted beat to its result strobe.
  localparam int unsigned LATENCY = 8;

  typedef enum logic [1:0] {
    OP_FWD   = 2'd0,
    OP_INV   = 2'd1,
    OP_SCALE = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_TW_SHIFT  = 3'd0,
    REG_TW_MASK   = 3'd1,
    REG_OFFSET    = 3'd2,
    REG_RD_SHIFT  = 3'd3,
    REG_RD_MASK   = 3'd4,
    REG_RD_FOLD   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic        reduce_first;
    logic        no_twiddle;
    logic [63:0] first_in;
    logic [63:0] second_in;
    logic [63:0] twiddle;
  } in_t;

  typedef struct packed {
    logic [63:0] first_out;
    logic [63:0] second_out;
  } out_t;

endpackage

// ----- src/ntt_lazy_butterfly_unit.sv -----
`timescale 1ns / 1ps

// Lazy-reduction NTT butterfly, one lane, fully pipelined.
// Input: a beat is taken at a clock edge where start is high and busy is low.
// busy is low whenever reset is released, so a new beat can enter every cycle.
// Each beat carries the operation (forward, inverse or scale), the pre-fold and
// no-twiddle flags, both operands and the packed twiddle.
// Output: every beat gives one result, shown on out_data for a single cycle with
// out_valid high. Results leave in the order beats came in. The receiver cannot
// stall the block.
// Throughput is one beat per cycle; the datapath has eight register
// stages: operand split, fold multiply, fold add, butterfly add, twiddle split,
// twiddle multiply, product sum, and the final add/subtract.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only
// while no result is outstanding. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) restores the register defaults and drops all
// beats in flight; no result appears for them.
module ntt_lazy_butterfly_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nlbu_pkg::in_t       in_data,
  output logic                out_valid,
  output nlbu_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import nlbu_pkg::*;

  logic        accept;
  logic [LATENCY-1:0] vld_r;

  // Configuration registers.
  logic [5:0]  tw_shift_r;
  logic [63:0] tw_mask_r;
  logic [63:0] offset_r;
  logic [5:0]  rd_shift_r;
  logic [63:0] rd_mask_r;
  logic [31:0] rd_fold_r;

  // Stage 1: operand split for the fold.
  logic [1:0]  s1_op_r;
  logic        s1_skip_r;
  logic [63:0] s1_tw_r;
  logic [63:0] s1_alo_r, s1_blo_r;
  logic [31:0] s1_ahi_r, s1_bhi_r;
  // Stage 2: fold products.
  logic [1:0]  s2_op_r;
  logic        s2_skip_r;
  logic [63:0] s2_tw_r;
  logic [63:0] s2_alo_r, s2_blo_r, s2_pa_r, s2_pb_r;
  // Stage 3: folded operands.
  logic [1:0]  s3_op_r;
  logic        s3_skip_r;
  logic [63:0] s3_tw_r;
  logic [63:0] s3_a_r, s3_b_r;
  // Stage 4: butterfly sums and the operand for the twiddle.
  logic [1:0]  s4_op_r;
  logic        s4_skip_r;
  logic [63:0] s4_tw_r;
  logic [63:0] s4_a_r, s4_r0_r, s4_x_r;
  logic [63:0] s4_x_nxt;
  // Stage 5: twiddle split.
  logic [1:0]  s5_op_r;
  logic        s5_skip_r;
  logic [63:0] s5_tw_r;
  logic [63:0] s5_a_r, s5_ao_r, s5_r0_r, s5_x_r;
  logic [31:0] s5_xl_r, s5_xh_r;
  logic [63:0] s5_xsh;
  // Stage 6: twiddle products.
  logic [1:0]  s6_op_r;
  logic        s6_skip_r;
  logic [63:0] s6_a_r, s6_ao_r, s6_r0_r, s6_x_r, s6_p0_r, s6_p1_r;
  // Stage 7: twiddle result.
  logic [1:0]  s7_op_r;
  logic [63:0] s7_a_r, s7_ao_r, s7_r0_r, s7_m_r;
  // Stage 8: output register.
  out_t        out_r, out_nxt;

  logic [63:0] ash, bsh;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_shift_r <= 6'd32;
      tw_mask_r  <= 64'h0000_0000_FFFF_FFFF;
      offset_r   <= '0;
      rd_shift_r <= 6'd32;
      rd_mask_r  <= 64'h0000_0000_FFFF_FFFF;
      rd_fold_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TW_SHIFT: tw_shift_r <= cfg_wdata[5:0];
        REG_TW_MASK:  tw_mask_r  <= cfg_wdata;
        REG_OFFSET:   offset_r   <= cfg_wdata;
        REG_RD_SHIFT: rd_shift_r <= cfg_wdata[5:0];
        REG_RD_MASK:  rd_mask_r  <= cfg_wdata;
        REG_RD_FOLD:  rd_fold_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], accept};
    end
  end

  assign ash = in_data.first_in >> rd_shift_r;
  assign bsh = in_data.second_in >> rd_shift_r;

  // Without the fold the high part is forced to zero, so the add stage passes
  // the operand through untouched.
  always_ff @(posedge clk) begin
    s1_op_r   <= in_data.operation;
    s1_skip_r <= in_data.no_twiddle;
    s1_tw_r   <= in_data.twiddle;
    if (in_data.reduce_first) begin
      s1_alo_r <= in_data.first_in & rd_mask_r;
      s1_blo_r <= in_data.second_in & rd_mask_r;
      s1_ahi_r <= ash[31:0];
      s1_bhi_r <= bsh[31:0];
    end else begin
      s1_alo_r <= in_data.first_in;
      s1_blo_r <= in_data.second_in;
      s1_ahi_r <= '0;
      s1_bhi_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r   <= s1_op_r;
    s2_skip_r <= s1_skip_r;
    s2_tw_r   <= s1_tw_r;
    s2_alo_r  <= s1_alo_r;
    s2_blo_r  <= s1_blo_r;
    s2_pa_r   <= 64'(s1_ahi_r) * 64'(rd_fold_r);
    s2_pb_r   <= 64'(s1_bhi_r) * 64'(rd_fold_r);
  end

  always_ff @(posedge clk) begin
    s3_op_r   <= s2_op_r;
    s3_skip_r <= s2_skip_r;
    s3_tw_r   <= s2_tw_r;
    s3_a_r    <= s2_alo_r + s2_pa_r;
    s3_b_r    <= s2_blo_r + s2_pb_r;
  end

  always_comb begin
    unique case (s3_op_r)
      OP_FWD:   s4_x_nxt = s3_a_r + offset_r - s3_b_r;
      OP_INV:   s4_x_nxt = s3_b_r;
      OP_SCALE: s4_x_nxt = s3_a_r;
      default:  s4_x_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    s4_op_r   <= s3_op_r;
    s4_skip_r <= s3_skip_r;
    s4_tw_r   <= s3_tw_r;
    s4_a_r    <= s3_a_r;
    s4_r0_r   <= s3_a_r + s3_b_r;
    s4_x_r    <= s4_x_nxt;
  end

  assign s5_xsh = s4_x_r >> tw_shift_r;

  always_ff @(posedge clk) begin
    s5_op_r   <= s4_op_r;
    s5_skip_r <= s4_skip_r;
    s5_tw_r   <= s4_tw_r;
    s5_a_r    <= s4_a_r;
    s5_ao_r   <= s4_a_r + offset_r;
    s5_r0_r   <= s4_r0_r;
    s5_x_r    <= s4_x_r;
    s5_xl_r   <= s4_x_r[31:0] & tw_mask_r[31:0];
    s5_xh_r   <= s5_xsh[31:0];
  end

  always_ff @(posedge clk) begin
    s6_op_r   <= s5_op_r;
    s6_skip_r <= s5_skip_r;
    s6_a_r    <= s5_a_r;
    s6_ao_r   <= s5_ao_r;
    s6_r0_r   <= s5_r0_r;
    s6_x_r    <= s5_x_r;
    s6_p0_r   <= 64'(s5_xl_r) * 64'(s5_tw_r[31:0]);
    s6_p1_r   <= 64'(s5_xh_r) * 64'(s5_tw_r[63:32]);
  end

  always_ff @(posedge clk) begin
    s7_op_r <= s6_op_r;
    s7_a_r  <= s6_a_r;
    s7_ao_r <= s6_ao_r;
    s7_r0_r <= s6_r0_r;
    s7_m_r  <= s6_skip_r ? s6_x_r : (s6_p0_r + s6_p1_r);
  end

  always_comb begin
    unique case (s7_op_r)
      OP_FWD: begin
        out_nxt.first_out  = s7_r0_r;
        out_nxt.second_out = s7_m_r;
      end
      OP_INV: begin
        out_nxt.first_out  = s7_a_r + s7_m_r;
        out_nxt.second_out = s7_ao_r - s7_m_r;
      end
      OP_SCALE: begin
        out_nxt.first_out  = s7_m_r;
        out_nxt.second_out = '0;
      end
      default: begin
        out_nxt.first_out  = '0;
        out_nxt.second_out = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[LATENCY-1];
  assign out_data  = out_r;

`include "assert_macros.svh"

  // A result strobe must belong to a beat accepted at the depth of the datapath.
  `ASSERT_IMPLY(a_strobe_from_beat, clk, rst_n, out_valid, $past(accept, LATENCY))

  // Scaling always gives a zero second result.
  `ASSERT_IMPLY(a_scale_zero, clk, rst_n,
      out_valid && $past(accept && in_data.operation == OP_SCALE, LATENCY),
      out_data.second_out == 64'd0)

  // The unused operation code yields an all-zero result.
  `ASSERT_IMPLY(a_unused_op_zero, clk, rst_n,
      out_valid && $past(accept && in_data.operation == OP_SPARE, LATENCY),
      out_data.first_out == 64'd0 && out_data.second_out == 64'd0)

endmodule
